// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// clocked implication check, disabled while reset is high
`define ASSERT_IMPL(label, clk_sig, rst_sig, cond, prop, msg) \
  `ASSERT_CLK(label, clk_sig, rst_sig, (cond) |-> (prop), msg)

`endif

// File: rtl/dnsax_pkg.sv
// types and constants of the dns response a-record extractor
// no dependencies; used by dnsax_parser and the top level
package dnsax_pkg;

  // width of the per-name label counter
  localparam int LABEL_W = 7;

  // transaction id register value after reset
  localparam logic [15:0] TXID_RESET = 16'h1234;

  // header and record constants
  localparam logic [7:0]  PTR_MASK       = 8'hC0;
  localparam logic [15:0] FLAG_QR        = 16'h8000;
  localparam logic [15:0] FLAG_RCODE     = 16'h000F;
  localparam logic [15:0] TYPE_A         = 16'h0001;
  localparam logic [15:0] CLASS_IN       = 16'h0001;
  localparam logic [15:0] A_RDLEN        = 16'd4;
  localparam logic [3:0]  HDR_LAST_BYTE  = 4'd11;
  localparam logic [3:0]  QTAIL_BYTES    = 4'd4;
  localparam logic [3:0]  AFIXED_LAST    = 4'd9;
  localparam logic [3:0]  ADDR_BYTES     = 4'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_TXID      = 3'd2;
  localparam logic [2:0] ST_NOT_RESP  = 3'd3;
  localparam logic [2:0] ST_RCODE     = 3'd4;
  localparam logic [2:0] ST_NO_ANS    = 3'd5;
  localparam logic [2:0] ST_MALFORMED = 3'd6;
  localparam logic [2:0] ST_NO_A      = 3'd7;

  // parse phases
  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_NAME   = 4'd1,
    PH_LABEL  = 4'd2,
    PH_PTR    = 4'd3,
    PH_QTAIL  = 4'd4,
    PH_AFIXED = 4'd5,
    PH_RDATA  = 4'd6,
    PH_ADDR   = 4'd7,
    PH_FOUND  = 4'd8,
    PH_TRAIL  = 4'd9,
    PH_DONE   = 4'd10
  } phase_t;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic        found;
    logic [31:0] address;
    logic [2:0]  status;
  } out_item_t;

endpackage

// File: rtl/dns_response_a_record_extractor.sv
// dns response a-record extractor: config register, parser and result register
// depends on dnsax_pkg, dnsax_parser and assert_macros.svh
//
// usage:
//   in_valid/in_stall/in_data carry one packet byte per transaction, with
//   last_byte set on the final byte of the packet. out_valid/out_stall/out_data
//   carry one result per packet (found, address, status), produced by the
//   transaction that carries last_byte.
//   cfg_wr_en/cfg_wr_data write the expected transaction id; write only
//   between packets.
// timing:
//   one byte per cycle unless a last byte is held off by in_stall; the parse
//   step is one pass of combinational logic between the parser state registers
//   and the result register; a result is valid in the cycle after its last byte.
// reset:
//   synchronous rst returns the parser to the header phase, drops out_valid and
//   sets the expected id to 0x1234.
// stall:
//   while a result waits under out_stall, non-last bytes are still accepted;
//   only a byte marked last is held off until the result register frees up.
`include "assert_macros.svh"

module dns_response_a_record_extractor #(
  parameter int MAX_LABELS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dnsax_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dnsax_pkg::out_item_t out_data
);

  logic                 out_blocked;
  logic [15:0]          expected_txid;
  logic                 in_accept;
  logic                 result_valid;
  dnsax_pkg::out_item_t result;

  // transaction id register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_txid <= dnsax_pkg::TXID_RESET;
    end else if (cfg_wr_en) begin
      expected_txid <= cfg_wr_data;
    end
  end

  // only a last byte needs the result register
  assign out_blocked = out_valid && out_stall;
  assign in_stall  = out_blocked && in_data.last_byte;
  assign in_accept = in_valid && !in_stall;

  dnsax_parser #(
    .MAX_LABELS(MAX_LABELS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .item         (in_data),
    .expected_txid(expected_txid),
    .result_valid (result_valid),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      out_data <= result;
    end
  end

  // checks
  `ASSERT_IMPL(a_found_ok, clk, rst, out_valid && out_data.found, out_data.status == dnsax_pkg::ST_OK, "found result without ok status")
  `ASSERT_IMPL(a_addr_zero, clk, rst, out_valid && !out_data.found, out_data.address == 32'd0, "address nonzero without found")
  `ASSERT_CLK(a_last_gives_result, clk, rst, in_accept && in_data.last_byte |=> out_valid, "last byte did not produce a result")

endmodule

// File: rtl/dnsax_parser.sv
// byte-wise dns response parser state machine
// depends on dnsax_pkg; one byte consumed per accepted transaction
module dnsax_parser #(
  parameter int MAX_LABELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  dnsax_pkg::in_item_t item,
  input  logic [15:0]         expected_txid,
  output logic                result_valid,
  output dnsax_pkg::out_item_t result
);

  localparam logic [dnsax_pkg::LABEL_W-1:0] LABEL_LIMIT = dnsax_pkg::LABEL_W'(MAX_LABELS);

  dnsax_pkg::phase_t parse_phase, parse_phase_next, phase_c;
  logic [3:0]  field_byte_count, field_byte_count_next, fbc_c;
  logic [15:0] header_flags, header_flags_next, flags_c;
  logic [15:0] questions_left, questions_left_next, quest_c;
  logic [15:0] answers_left, answers_left_next, ans_c;
  logic [15:0] skip_left, skip_left_next, skip_c;
  logic [dnsax_pkg::LABEL_W-1:0] label_count, label_count_next, label_c;
  logic [15:0] record_type, record_type_next, type_c;
  logic [15:0] record_class, record_class_next, class_c;
  logic [15:0] record_length, record_length_next, len_c;
  logic [31:0] address_shift, address_shift_next, addr_c;
  logic [2:0]  packet_status, packet_status_next, pstat_c;
  logic [7:0]  b;
  logic [15:0] ans_dec;
  logic [3:0]  fbc_inc;

  assign b       = item.data_byte;
  assign ans_dec = answers_left - 16'd1;
  assign fbc_inc = field_byte_count + 4'd1;

  // consume one byte
  always_comb begin
    phase_c = parse_phase;
    fbc_c   = field_byte_count;
    flags_c = header_flags;
    quest_c = questions_left;
    ans_c   = answers_left;
    skip_c  = skip_left;
    label_c = label_count;
    type_c  = record_type;
    class_c = record_class;
    len_c   = record_length;
    addr_c  = address_shift;
    pstat_c = packet_status;
    case (parse_phase)
      dnsax_pkg::PH_HDR: begin
        case (field_byte_count)
          4'd0, 4'd2: flags_c = {b, 8'h00};
          4'd1: begin
            flags_c = header_flags | {8'h00, b};
            if (flags_c != expected_txid) pstat_c = dnsax_pkg::ST_TXID;
          end
          4'd3: flags_c = header_flags | {8'h00, b};
          4'd4: quest_c = {b, 8'h00};
          4'd5: quest_c = questions_left | {8'h00, b};
          4'd6: ans_c = {b, 8'h00};
          4'd7: ans_c = answers_left | {8'h00, b};
          default: ;
        endcase
        if (field_byte_count >= dnsax_pkg::HDR_LAST_BYTE) begin
          fbc_c   = 4'd0;
          label_c = '0;
          if (pstat_c == dnsax_pkg::ST_TXID) begin
            phase_c = dnsax_pkg::PH_DONE;
          end else if ((flags_c & dnsax_pkg::FLAG_QR) == 16'd0) begin
            pstat_c = dnsax_pkg::ST_NOT_RESP;
            phase_c = dnsax_pkg::PH_DONE;
          end else if ((flags_c & dnsax_pkg::FLAG_RCODE) != 16'd0) begin
            pstat_c = dnsax_pkg::ST_RCODE;
            phase_c = dnsax_pkg::PH_DONE;
          end else if (ans_c == 16'd0) begin
            pstat_c = dnsax_pkg::ST_NO_ANS;
            phase_c = dnsax_pkg::PH_DONE;
          end else begin
            phase_c = dnsax_pkg::PH_NAME;
          end
        end else begin
          fbc_c = fbc_inc;
        end
      end
      dnsax_pkg::PH_NAME: begin
        if (label_count >= LABEL_LIMIT) begin
          pstat_c = dnsax_pkg::ST_MALFORMED;
          phase_c = dnsax_pkg::PH_DONE;
        end else if (b == 8'd0) begin
          label_c = '0;
          fbc_c   = 4'd0;
          phase_c = (questions_left != 16'd0) ? dnsax_pkg::PH_QTAIL : dnsax_pkg::PH_AFIXED;
        end else if ((b & dnsax_pkg::PTR_MASK) == dnsax_pkg::PTR_MASK) begin
          phase_c = dnsax_pkg::PH_PTR;
        end else begin
          skip_c  = {8'h00, b};
          label_c = label_count + 1'b1;
          phase_c = dnsax_pkg::PH_LABEL;
        end
      end
      dnsax_pkg::PH_LABEL: begin
        skip_c = skip_left - 16'd1;
        if (skip_c == 16'd0) phase_c = dnsax_pkg::PH_NAME;
      end
      dnsax_pkg::PH_PTR: begin
        // second pointer byte closes the name
        label_c = '0;
        fbc_c   = 4'd0;
        phase_c = (questions_left != 16'd0) ? dnsax_pkg::PH_QTAIL : dnsax_pkg::PH_AFIXED;
      end
      dnsax_pkg::PH_QTAIL: begin
        fbc_c = fbc_inc;
        if (fbc_c >= dnsax_pkg::QTAIL_BYTES) begin
          fbc_c   = 4'd0;
          quest_c = questions_left - 16'd1;
          label_c = '0;
          phase_c = dnsax_pkg::PH_NAME;
        end
      end
      dnsax_pkg::PH_AFIXED: begin
        case (field_byte_count)
          4'd0: type_c  = {b, 8'h00};
          4'd1: type_c  = record_type | {8'h00, b};
          4'd2: class_c = {b, 8'h00};
          4'd3: class_c = record_class | {8'h00, b};
          4'd8: len_c   = {b, 8'h00};
          4'd9: len_c   = record_length | {8'h00, b};
          default: ;
        endcase
        if (field_byte_count < dnsax_pkg::AFIXED_LAST) begin
          fbc_c = fbc_inc;
        end else begin
          fbc_c = 4'd0;
          if (type_c == dnsax_pkg::TYPE_A && class_c == dnsax_pkg::CLASS_IN &&
              len_c == dnsax_pkg::A_RDLEN) begin
            addr_c  = 32'd0;
            phase_c = dnsax_pkg::PH_ADDR;
          end else if (len_c == 16'd0) begin
            ans_c   = ans_dec;
            label_c = '0;
            phase_c = (ans_dec == 16'd0) ? dnsax_pkg::PH_TRAIL : dnsax_pkg::PH_NAME;
          end else begin
            skip_c  = len_c;
            phase_c = dnsax_pkg::PH_RDATA;
          end
        end
      end
      dnsax_pkg::PH_RDATA: begin
        skip_c = skip_left - 16'd1;
        if (skip_c == 16'd0) begin
          ans_c   = ans_dec;
          label_c = '0;
          phase_c = (ans_dec == 16'd0) ? dnsax_pkg::PH_TRAIL : dnsax_pkg::PH_NAME;
        end
      end
      dnsax_pkg::PH_ADDR: begin
        addr_c = {address_shift[23:0], b};
        fbc_c  = fbc_inc;
        if (fbc_c >= dnsax_pkg::ADDR_BYTES) begin
          fbc_c   = 4'd0;
          phase_c = dnsax_pkg::PH_FOUND;
        end
      end
      default: ;
    endcase
  end

  // result on the marked last byte, then clear for the next packet
  always_comb begin
    result.found   = 1'b0;
    result.address = 32'd0;
    case (phase_c)
      dnsax_pkg::PH_HDR:   result.status = dnsax_pkg::ST_SHORT;
      dnsax_pkg::PH_DONE:  result.status = pstat_c;
      dnsax_pkg::PH_FOUND: begin
        result.status  = dnsax_pkg::ST_OK;
        result.found   = 1'b1;
        result.address = addr_c;
      end
      dnsax_pkg::PH_TRAIL: result.status = dnsax_pkg::ST_NO_A;
      default:             result.status = dnsax_pkg::ST_MALFORMED;
    endcase
    result_valid = accept && item.last_byte;

    parse_phase_next        = parse_phase;
    field_byte_count_next   = field_byte_count;
    header_flags_next       = header_flags;
    questions_left_next     = questions_left;
    answers_left_next       = answers_left;
    skip_left_next          = skip_left;
    label_count_next        = label_count;
    record_type_next        = record_type;
    record_class_next       = record_class;
    record_length_next      = record_length;
    address_shift_next      = address_shift;
    packet_status_next      = packet_status;
    if (accept) begin
      if (item.last_byte) begin
        parse_phase_next      = dnsax_pkg::PH_HDR;
        field_byte_count_next = 4'd0;
        header_flags_next     = 16'd0;
        questions_left_next   = 16'd0;
        answers_left_next     = 16'd0;
        skip_left_next        = 16'd0;
        label_count_next      = '0;
        record_type_next      = 16'd0;
        record_class_next     = 16'd0;
        record_length_next    = 16'd0;
        address_shift_next    = 32'd0;
        packet_status_next    = dnsax_pkg::ST_OK;
      end else begin
        parse_phase_next      = phase_c;
        field_byte_count_next = fbc_c;
        header_flags_next     = flags_c;
        questions_left_next   = quest_c;
        answers_left_next     = ans_c;
        skip_left_next        = skip_c;
        label_count_next      = label_c;
        record_type_next      = type_c;
        record_class_next     = class_c;
        record_length_next    = len_c;
        address_shift_next    = addr_c;
        packet_status_next    = pstat_c;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= dnsax_pkg::PH_HDR;
      field_byte_count <= 4'd0;
      header_flags     <= 16'd0;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      skip_left        <= 16'd0;
      label_count      <= '0;
      record_type      <= 16'd0;
      record_class     <= 16'd0;
      record_length    <= 16'd0;
      address_shift    <= 32'd0;
      packet_status    <= dnsax_pkg::ST_OK;
    end else begin
      parse_phase      <= parse_phase_next;
      field_byte_count <= field_byte_count_next;
      header_flags     <= header_flags_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      skip_left        <= skip_left_next;
      label_count      <= label_count_next;
      record_type      <= record_type_next;
      record_class     <= record_class_next;
      record_length    <= record_length_next;
      address_shift    <= address_shift_next;
      packet_status    <= packet_status_next;
    end
  end

endmodule

// File: dv/dns_response_a_record_extractor_tb.sv
// self-checking testbench for dns_response_a_record_extractor
// depends on dnsax_pkg and the rtl top level; packets are built here and
// every result is compared with a cycle-free prediction of the parser
module dns_response_a_record_extractor_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LABEL_LIMIT = 64;
  localparam int WATCHDOG    = 2000;
  localparam int PHASE_BYTES = 130;
  localparam int PHASE_PKTS  = 2;

  // prediction of the parser plus the queue of results still to arrive
  class extract_tracker;
    logic [15:0]          txid;
    dnsax_pkg::phase_t    phase;
    logic [3:0]           fcount;
    logic [15:0]          flags, qleft, aleft, skip, rtype, rclass, rlen;
    logic [6:0]           labels;
    logic [31:0]          addr;
    logic [2:0]           pstat;
    dnsax_pkg::out_item_t pending_results[$];
    int                   errors;
    int                   status_seen[8];

    function new();
      txid = dnsax_pkg::TXID_RESET;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear();
    endfunction

    function void clear();
      phase = dnsax_pkg::PH_HDR;
      fcount = '0;
      flags = '0;
      qleft = '0;
      aleft = '0;
      skip = '0;
      rtype = '0;
      rclass = '0;
      rlen = '0;
      labels = '0;
      addr = '0;
      pstat = dnsax_pkg::ST_OK;
    endfunction

    function void settle(logic [2:0] code);
      pstat = code;
      phase = dnsax_pkg::PH_DONE;
    endfunction

    function void end_name();
      labels = '0;
      fcount = '0;
      phase = (qleft != 0) ? dnsax_pkg::PH_QTAIL : dnsax_pkg::PH_AFIXED;
    endfunction

    function void end_answer();
      aleft = aleft - 16'd1;
      labels = '0;
      phase = (aleft == 0) ? dnsax_pkg::PH_TRAIL : dnsax_pkg::PH_NAME;
    endfunction

    // one accepted byte; a byte marked last queues the expected result
    function void take_byte(dnsax_pkg::in_item_t item);
      logic [7:0]           b;
      dnsax_pkg::out_item_t r;
      b = item.data_byte;
      case (phase)
        dnsax_pkg::PH_HDR: begin
          case (fcount)
            4'd0, 4'd2: flags = {b, 8'h00};
            4'd1: begin
              flags = flags | {8'h00, b};
              if (flags != txid) pstat = dnsax_pkg::ST_TXID;
            end
            4'd3: flags = flags | {8'h00, b};
            4'd4: qleft = {b, 8'h00};
            4'd5: qleft = qleft | {8'h00, b};
            4'd6: aleft = {b, 8'h00};
            4'd7: aleft = aleft | {8'h00, b};
            default: ;
          endcase
          // header decision: txid, response bit, rcode, answer count
          if (fcount >= dnsax_pkg::HDR_LAST_BYTE) begin
            fcount = '0;
            labels = '0;
            if (pstat == dnsax_pkg::ST_TXID) settle(dnsax_pkg::ST_TXID);
            else if ((flags & dnsax_pkg::FLAG_QR) == 0) settle(dnsax_pkg::ST_NOT_RESP);
            else if ((flags & dnsax_pkg::FLAG_RCODE) != 0) settle(dnsax_pkg::ST_RCODE);
            else if (aleft == 0) settle(dnsax_pkg::ST_NO_ANS);
            else phase = dnsax_pkg::PH_NAME;
          end else begin
            fcount = fcount + 4'd1;
          end
        end
        dnsax_pkg::PH_NAME: begin
          if (labels >= LABEL_LIMIT) settle(dnsax_pkg::ST_MALFORMED);
          else if (b == 8'h00) end_name();
          else if ((b & dnsax_pkg::PTR_MASK) == dnsax_pkg::PTR_MASK) phase = dnsax_pkg::PH_PTR;
          else begin
            skip = {8'h00, b};
            labels = labels + 7'd1;
            phase = dnsax_pkg::PH_LABEL;
          end
        end
        dnsax_pkg::PH_LABEL: begin
          skip = skip - 16'd1;
          if (skip == 0) phase = dnsax_pkg::PH_NAME;
        end
        dnsax_pkg::PH_PTR: end_name();
        dnsax_pkg::PH_QTAIL: begin
          fcount = fcount + 4'd1;
          if (fcount >= dnsax_pkg::QTAIL_BYTES) begin
            fcount = '0;
            qleft = qleft - 16'd1;
            labels = '0;
            phase = dnsax_pkg::PH_NAME;
          end
        end
        dnsax_pkg::PH_AFIXED: begin
          case (fcount)
            4'd0: rtype = {b, 8'h00};
            4'd1: rtype = rtype | {8'h00, b};
            4'd2: rclass = {b, 8'h00};
            4'd3: rclass = rclass | {8'h00, b};
            4'd8: rlen = {b, 8'h00};
            4'd9: rlen = rlen | {8'h00, b};
            default: ;
          endcase
          if (fcount < dnsax_pkg::AFIXED_LAST) begin
            fcount = fcount + 4'd1;
          end else begin
            fcount = '0;
            if (rtype == dnsax_pkg::TYPE_A && rclass == dnsax_pkg::CLASS_IN &&
                rlen == dnsax_pkg::A_RDLEN) begin
              addr = '0;
              phase = dnsax_pkg::PH_ADDR;
            end else if (rlen == 0) begin
              end_answer();
            end else begin
              skip = rlen;
              phase = dnsax_pkg::PH_RDATA;
            end
          end
        end
        dnsax_pkg::PH_RDATA: begin
          skip = skip - 16'd1;
          if (skip == 0) end_answer();
        end
        dnsax_pkg::PH_ADDR: begin
          addr = {addr[23:0], b};
          fcount = fcount + 4'd1;
          if (fcount >= dnsax_pkg::ADDR_BYTES) begin
            fcount = '0;
            phase = dnsax_pkg::PH_FOUND;
          end
        end
        default: ;
      endcase

      if (item.last_byte) begin
        r = '0;
        case (phase)
          dnsax_pkg::PH_HDR:   r.status = dnsax_pkg::ST_SHORT;
          dnsax_pkg::PH_DONE:  r.status = pstat;
          dnsax_pkg::PH_FOUND: begin
            r.found = 1'b1;
            r.address = addr;
            r.status = dnsax_pkg::ST_OK;
          end
          dnsax_pkg::PH_TRAIL: r.status = dnsax_pkg::ST_NO_A;
          default:             r.status = dnsax_pkg::ST_MALFORMED;
        endcase
        pending_results.push_back(r);
        status_seen[r.status]++;
        clear();
      end
    endfunction

    function void report(string what, logic [31:0] e, logic [31:0] g);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, e, g);
    endfunction

    // compare one accepted result with the oldest expected one
    function void match_result(dnsax_pkg::out_item_t got);
      dnsax_pkg::out_item_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no packet pending: found %0b address %h status %0d",
                 $time, got.found, got.address, got.status);
        return;
      end
      exp = pending_results.pop_front();
      if (got.found !== exp.found) report("found", 32'(exp.found), 32'(got.found));
      if (got.address !== exp.address) report("address", exp.address, got.address);
      if (got.status !== exp.status) report("status", 32'(exp.status), 32'(got.status));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [15:0]          cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  dnsax_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  dnsax_pkg::out_item_t out_data;

  extract_tracker sb;
  logic [7:0]     pkt[$];
  bit             calm;
  int             bytes_sent;
  int             packets_sent;
  int             quiet;

  dns_response_a_record_extractor #(
    .MAX_LABELS(LABEL_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length for either side: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // packet building helpers, all appending to pkt
  function automatic void put16(logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_rand(int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] id, logic [15:0] fl,
                                     logic [15:0] qd, logic [15:0] an);
    put16(id);
    put16(fl);
    put16(qd);
    put16(an);
    put_rand(4);
  endfunction

  function automatic void put_name(int nlab, int maxlen, bit ptr);
    int len;
    repeat (nlab) begin
      len = $urandom_range(1, maxlen);
      pkt.push_back(8'(len));
      put_rand(len);
    end
    if (ptr) begin
      pkt.push_back({2'b11, 6'($urandom)});
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'h00);
    end
  endfunction

  function automatic void put_rr(logic [15:0] rt, logic [15:0] rc, logic [15:0] rl,
                                 int ndata);
    put_name($urandom_range(0, 2), 10, 1'($urandom_range(0, 1)));
    put16(rt);
    put16(rc);
    put_rand(4);
    put16(rl);
    put_rand(ndata);
  endfunction

  // send pkt byte by byte, last byte marked; called and returns at a falling edge
  task automatic send_packet();
    dnsax_pkg::in_item_t item;
    int                  gap;
    for (int i = 0; i < pkt.size(); i++) begin
      item.data_byte = pkt[i];
      item.last_byte = (i == pkt.size() - 1);
      in_data <= item;
      in_valid <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.take_byte(item);
      bytes_sent++;
      @(negedge clk);
      gap = idle_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    packets_sent++;
    pkt.delete();
  endtask

  // hold the sender until every expected result is back
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // result side: random stall runs
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) hold_left--;
      else hold_left = idle_len();
      out_stall <= (hold_left > 0);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.match_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
        if (quiet >= WATCHDOG) begin
          $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
          $display("dns_response_a_record_extractor verification failed");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    int          r;
    int          n;
    int          e;
    int          qd;
    int          an;
    int          start_bytes;
    int          start_pkts;
    logic [15:0] id;

    sb = new();
    calm = 1'b0;
    bytes_sent = 0;
    packets_sent = 0;
    quiet = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed packets, txid still at its reset value
    // address all ones, ends right on the last address byte
    put_header(dnsax_pkg::TXID_RESET, 16'h8180, 16'd1, 16'd1);
    put_name(2, 8, 1'b0);
    put_rand(4);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 0);
    put16(16'hFFFF);
    put16(16'hFFFF);
    send_packet();
    // address 0.0.0.0 followed by ignored bytes
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'd1);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 0);
    put16(16'h0000);
    put16(16'h0000);
    put_rand(5);
    send_packet();
    // short headers
    pkt.push_back(8'h00);
    send_packet();
    repeat (11) pkt.push_back(8'hFF);
    send_packet();
    // header checks, the first three with later checks failing too
    put_header(~dnsax_pkg::TXID_RESET, 16'h000F, 16'd0, 16'd0);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h7FFF, 16'd1, 16'd1);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8003, 16'd0, 16'd0);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'hFFF0, 16'd5, 16'd0);
    send_packet();
    // truncation: after header, in a question, in a pointer, in the address
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'd1);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd1);
    put_name(1, 5, 1'b0);
    put_rand(2);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd1);
    pkt.push_back(8'hC0);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'd1);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 2);
    send_packet();
    // no matching answer, with and without trailing bytes
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd2);
    put_name(1, 3, 1'b1);
    put_rand(4);
    put_rr(16'd5, dnsax_pkg::CLASS_IN, 16'd3, 3);
    put_rr(dnsax_pkg::TYPE_A, 16'd3, dnsax_pkg::A_RDLEN, 4);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'd1);
    put_rr(16'd28, dnsax_pkg::CLASS_IN, 16'd16, 16);
    put_rand(3);
    send_packet();
    // label limit: one label over, then exactly at the limit
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd1);
    put_name(LABEL_LIMIT, 1, 1'b0);
    put_rand(4);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd1);
    put_name(LABEL_LIMIT - 1, 1, 1'b0);
    put_rand(4);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
    send_packet();
    // lengths 0x40 and 0xbf are plain labels
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd1, 16'd1);
    pkt.push_back(8'h40);
    put_rand(64);
    pkt.push_back(8'hBF);
    put_rand(191);
    pkt.push_back(8'h00);
    put_rand(4);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
    send_packet();
    // empty rdata, wrong rdlength, then a match
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'd3);
    put_rr(16'd16, dnsax_pkg::CLASS_IN, 16'd0, 0);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, 16'd6, 6);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
    send_packet();
    // maximum counts
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'hFFFF, 16'hFFFF);
    put_name(1, 3, 1'b0);
    put_rand(4);
    send_packet();
    put_header(dnsax_pkg::TXID_RESET, 16'h8000, 16'd0, 16'hFFFF);
    put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
    send_packet();

    // random phases, each with its own txid; the third runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained(3);
      case (ph)
        0:       id = 16'h0000;
        1:       id = 16'hFFFF;
        default: id = 16'($urandom);
      endcase
      cfg_wr_data <= id;
      cfg_wr_en <= 1'b1;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      sb.txid = id;
      calm = (ph == 2);
      start_bytes = bytes_sent;
      start_pkts = packets_sent;

      while (bytes_sent - start_bytes < PHASE_BYTES || packets_sent - start_pkts < PHASE_PKTS)
      begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          // well-formed response, sometimes cut short or padded
          qd = $urandom_range(0, 2);
          an = $urandom_range(1, 3);
          put_header(sb.txid, {1'b1, 11'($urandom), 4'h0}, 16'(qd), 16'(an));
          repeat (qd) begin
            put_name($urandom_range(0, 3), ($urandom_range(0, 19) == 0) ? 191 : 12,
                     $urandom_range(0, 2) == 0);
            put_rand(4);
          end
          repeat (an) begin
            case ($urandom_range(0, 7))
              0, 1, 2: put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
              3: put_rr(dnsax_pkg::TYPE_A, 16'($urandom_range(2, 65535)),
                        dnsax_pkg::A_RDLEN, 4);
              4: begin
                n = $urandom_range(0, 12);
                put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, 16'(n), n);
              end
              5:       put_rr(16'($urandom), 16'($urandom), 16'd0, 0);
              default: begin
                n = $urandom_range(1, 16);
                put_rr(16'($urandom_range(2, 65535)), dnsax_pkg::CLASS_IN, 16'(n), n);
              end
            endcase
          end
          if ($urandom_range(0, 9) == 0) put_rand($urandom_range(1, 6));
          if (r >= 50) begin
            n = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > n) void'(pkt.pop_back());
          end
        end else if (r < 72) begin
          // header failure of a random kind
          e = $urandom_range(0, 3);
          case (e)
            0: put_header(sb.txid ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                          16'($urandom), 16'($urandom));
            1: put_header(sb.txid, {1'b0, 15'($urandom)}, 16'($urandom), 16'($urandom));
            2: put_header(sb.txid, {1'b1, 11'($urandom), 4'($urandom_range(1, 15))},
                          16'($urandom), 16'($urandom));
            default: put_header(sb.txid, {1'b1, 11'($urandom), 4'h0}, 16'($urandom),
                                16'd0);
          endcase
          put_rand($urandom_range(0, 8));
        end else if (r < 80) begin
          put_rand($urandom_range(1, 11));
        end else if (r < 88) begin
          // noise, half of it with a matching txid
          if ($urandom_range(0, 1) == 1) put16(sb.txid);
          put_rand($urandom_range(12, 40));
        end else if (r < 94) begin
          // names around the label limit
          put_header(sb.txid, dnsax_pkg::FLAG_QR, 16'd1, 16'd1);
          put_name($urandom_range(LABEL_LIMIT - 2, LABEL_LIMIT + 2), 1, 1'b0);
          put_rand(4);
          put_rr(dnsax_pkg::TYPE_A, dnsax_pkg::CLASS_IN, dnsax_pkg::A_RDLEN, 4);
        end else begin
          // huge counts, packet ends early
          put_header(sb.txid, 16'h8100, 16'($urandom), 16'($urandom));
          repeat (2) begin
            put_name($urandom_range(0, 2), 6, 1'($urandom_range(0, 1)));
            put_rand(4);
          end
        end
        send_packet();
      end
    end

    wait_drained(10);
    $display("covered %0d packets in %0d bytes over 5 txid settings incl 0x0000 and 0xffff",
             packets_sent, bytes_sent);
    $display("results: ok %0d short %0d txid %0d notresp %0d rcode %0d noans %0d bad %0d noa %0d",
             sb.status_seen[dnsax_pkg::ST_OK], sb.status_seen[dnsax_pkg::ST_SHORT],
             sb.status_seen[dnsax_pkg::ST_TXID], sb.status_seen[dnsax_pkg::ST_NOT_RESP],
             sb.status_seen[dnsax_pkg::ST_RCODE], sb.status_seen[dnsax_pkg::ST_NO_ANS],
             sb.status_seen[dnsax_pkg::ST_MALFORMED], sb.status_seen[dnsax_pkg::ST_NO_A]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("dns_response_a_record_extractor verification clean");
    end else begin
      $display("dns_response_a_record_extractor verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dnsax_pkg.sv
rtl/dnsax_parser.sv
rtl/dns_response_a_record_extractor.sv
dv/dns_response_a_record_extractor_tb.sv
